// ----- sv/rsm_pkg.sv -----
// Shared types and constants for the motor, servo and mecanum PWM mixer.
// Used by every module of the block; depends on nothing.
package rsm_pkg;

    // Function codes of an input beat
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_MOTOR   = 2'd1;
    localparam logic [1:0] FUNC_SERVO   = 2'd2;
    localparam logic [1:0] FUNC_MECANUM = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_WDOG_TICKS = 2'd0;
    localparam logic [1:0] CFG_DEADBAND   = 2'd1;

    // Register reset values
    localparam logic [7:0] WDOG_TICKS_RST = 8'd50;
    localparam logic [6:0] DEADBAND_RST   = 7'd5;

    // PWM encoding
    localparam logic [12:0] PWM_FULL  = 13'd4096;
    localparam logic [3:0]  SERVO_CH0 = 4'd11;

    // Servo: floor(p*1638/1000) == (p*SERVO_K) >> SERVO_SH for 0 <= p <= SERVO_PMAX
    localparam logic [11:0] SERVO_PMAX = 12'd2500;
    localparam logic [21:0] SERVO_K    = 22'd3435135;
    localparam int          SERVO_SH   = 21;

    // Motor duty: floor(4095*m/100) == (m*DUTY_K) >> DUTY_SH for 0 <= m <= 100
    localparam logic [6:0]  MAG_MAX = 7'd100;
    localparam logic [21:0] DUTY_K  = 22'd2683700;
    localparam int          DUTY_SH = 16;

    // Queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        K_TICK,
        K_MOTOR,
        K_SERVO,
        K_MECANUM
    } t_kind;

    // Classified item: vals[0..3] hold value_a..value_d
    typedef struct packed {
        t_kind            kind;
        logic [3:0][15:0] vals;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One PWM channel write
    typedef struct packed {
        logic [3:0]  channel;
        logic [12:0] on_count;
        logic [12:0] off_count;
        logic        last;
    } t_wr;

endpackage

// ----- sv/robot_motor_servo_pwm_mixer.sv -----
// A command beat passes the front register and the queue; the back end applies it
// as it pops it and stays in S_IDLE. A tick is popped in S_IDLE and passes S_PLAN
// and S_PICK before its first write enters the output register. Per tick, the
// sequencer visits S_PICK per changed servo or motor, then writes in S_SERVO or
// S_MOTOR while the output is free: one write per servo, three per motor.
// Reset (synchronous, active low): commands zero, watchdog inactive, registers 50/5.
module robot_motor_servo_pwm_mixer #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_value_a,
    input  logic [15:0] i_value_b,
    input  logic [15:0] i_value_c,
    input  logic [15:0] i_value_d,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_channel,
    output logic [12:0] o_on_count,
    output logic [12:0] o_off_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import rsm_pkg::*;

    t_item   f_item;
    logic    f_push;
    t_item   q_head;
    t_q_stat q_stat;
    logic    b_pop;
    t_wr     b_wr;

    // Registers accept a write in every cycle
    assign o_cfg_ready = 1'b1;

    rsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_value_a  (i_value_a),
        .i_value_b  (i_value_b),
        .i_value_c  (i_value_c),
        .i_value_d  (i_value_d),
        .i_q_stat   (q_stat),
        .o_push     (f_push),
        .o_item     (f_item)
    );

    rsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    rsm_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (q_head),
        .i_q_stat    (q_stat),
        .o_pop       (b_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_wr        (b_wr)
    );

    // Split the write beat into its fields
    assign o_channel   = b_wr.channel;
    assign o_on_count  = b_wr.on_count;
    assign o_off_count = b_wr.off_count;
    assign o_last      = b_wr.last;

endmodule

// ----- sv/rsm_front.sv -----
// Input stage of the mixer: takes input beats, classifies the function code
// and hands classified items to the queue. Depends on rsm_pkg.
module rsm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_func,
    input  logic [15:0]    i_value_a,
    input  logic [15:0]    i_value_b,
    input  logic [15:0]    i_value_c,
    input  logic [15:0]    i_value_d,
    input  rsm_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output rsm_pkg::t_item o_item
);
    import rsm_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_kind kind;
    logic  accept;

    // Classify the function code
    always_comb begin
        unique case (i_func)
            FUNC_TICK:    kind = K_TICK;
            FUNC_MOTOR:   kind = K_MOTOR;
            FUNC_SERVO:   kind = K_SERVO;
            FUNC_MECANUM: kind = K_MECANUM;
            default:      kind = K_TICK;
        endcase
    end

    // Stall only while the held item cannot move into a full queue
    assign o_in_stall = r_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_item     = r_item;

    // Hold one classified beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind <= kind;
            r_item.vals <= {i_value_d, i_value_c, i_value_b, i_value_a};
        end
    end

endmodule

// ----- sv/rsm_queue.sv -----
// Short item queue between the front and back parts of the mixer.
// Flip-flop storage, first in first out. Depends on rsm_pkg.
module rsm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rsm_pkg::t_item   i_item,
    input  logic             i_pop,
    output rsm_pkg::t_item   o_head,
    output rsm_pkg::t_q_stat o_stat
);
    import rsm_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(Q_DEPTH) && !i_pop) |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

// ----- sv/rsm_back.sv -----
// Execution part of the mixer: applies commands, runs the watchdog and
// sequences PWM channel writes for each tick. Depends on rsm_pkg.
module rsm_back #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  rsm_pkg::t_item   i_head,
    input  rsm_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rsm_pkg::t_wr     o_wr
);
    import rsm_pkg::*;

    localparam int MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_PICK,
        S_SERVO,
        S_MOTOR,
        S_WDOG
    } t_state;

    t_state                  r_state;
    logic [7:0]              r_wdog_ticks;
    logic [6:0]              r_deadband;
    logic signed [15:0]      r_servo_cmd  [4];
    logic signed [15:0]      r_servo_sent [4];
    logic signed [17:0]      r_motor_cmd  [MOTOR_COUNT];
    logic signed [17:0]      r_motor_sent [MOTOR_COUNT];
    logic signed [15:0]      r_mec_cmd    [3];
    logic signed [15:0]      r_mec_sent   [3];
    logic                    r_mec_mode;
    logic signed [8:0]       r_wd;
    logic [3:0]              r_srv_pend;
    logic [MOTOR_COUNT-1:0]  r_mot_pend;
    logic [1:0]              r_srv_idx;
    logic [MW-1:0]           r_mot_idx;
    logic [1:0]              r_sub;
    logic [11:0]             r_p12;
    logic [6:0]              r_mag;
    logic                    r_neg;
    logic                    r_out_valid;
    t_wr                     r_out;

    logic                    out_free;
    logic                    out_load;
    logic                    mec_diff;
    logic signed [17:0]      mix [4];
    logic signed [17:0]      my;
    logic signed [17:0]      mx;
    logic signed [17:0]      mw;
    logic [1:0]              srv_low;
    logic [MW-1:0]           mot_low;
    logic signed [15:0]      pos;
    logic [11:0]             p12;
    logic signed [17:0]      mv;
    logic [17:0]             mag_abs;
    logic [6:0]              mag_sel;
    logic [33:0]             servo_prod;
    logic [28:0]             duty_prod;
    logic [12:0]             duty;
    logic [3:0]              mot_ch;
    logic [3:0]              srv_rest;
    logic [MOTOR_COUNT-1:0]  mot_rest;
    t_wr                     wr;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = out_free && (r_state == S_SERVO || r_state == S_MOTOR);
    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_out_valid = r_out_valid;
    assign o_wr        = r_out;

    // Mecanum mix of the current velocity commands
    assign my = 18'(r_mec_cmd[0]);
    assign mx = 18'(r_mec_cmd[1]);
    assign mw = 18'(r_mec_cmd[2]);
    assign mix[0] = my - mx - mw;
    assign mix[1] = my + mx - mw;
    assign mix[2] = my - mx + mw;
    assign mix[3] = my + mx + mw;
    assign mec_diff = (r_mec_cmd[0] != r_mec_sent[0]) || (r_mec_cmd[1] != r_mec_sent[1]) ||
                      (r_mec_cmd[2] != r_mec_sent[2]);

    // Pick the lowest pending servo and motor
    always_comb begin
        srv_low = '0;
        for (int i = 3; i >= 0; i--) begin
            if (r_srv_pend[i]) begin
                srv_low = 2'(i);
            end
        end
        mot_low = '0;
        for (int i = MOTOR_COUNT - 1; i >= 0; i--) begin
            if (r_mot_pend[i]) begin
                mot_low = MW'(i);
            end
        end
    end

    // Clamp the servo position into the exact range of the reciprocal
    always_comb begin
        pos = r_servo_cmd[srv_low];
        if (pos[15] || pos == 16'sd0) begin
            p12 = '0;
        end else if (pos > 16'(SERVO_PMAX)) begin
            p12 = SERVO_PMAX;
        end else begin
            p12 = pos[11:0];
        end
    end

    // Deadband and clamp the motor speed magnitude
    always_comb begin
        mv      = r_motor_cmd[mot_low];
        mag_abs = mv[17] ? 18'(-mv) : 18'(mv);
        if (mag_abs <= 18'(r_deadband)) begin
            mag_sel = '0;
        end else if (mag_abs > 18'(MAG_MAX)) begin
            mag_sel = MAG_MAX;
        end else begin
            mag_sel = mag_abs[6:0];
        end
    end

    // Scale into PWM counts
    assign servo_prod = 34'(r_p12) * 34'(SERVO_K);
    assign duty_prod  = 29'(r_mag) * 29'(DUTY_K);
    assign duty       = {1'b0, duty_prod[DUTY_SH+11:DUTY_SH]};
    assign mot_ch     = (4'(r_mot_idx) << 1) + 4'(r_mot_idx) + 4'(r_sub);

    // Pending work left once the current item is done
    always_comb begin
        srv_rest = r_srv_pend;
        srv_rest[r_srv_idx] = 1'b0;
        mot_rest = r_mot_pend;
        mot_rest[r_mot_idx] = 1'b0;
    end

    // Build the channel write of the current step
    always_comb begin
        wr.channel   = SERVO_CH0 + 4'(r_srv_idx);
        wr.on_count  = '0;
        wr.off_count = {1'b0, servo_prod[SERVO_SH+11:SERVO_SH]};
        wr.last      = (srv_rest == '0) && (r_mot_pend == '0);
        if (r_state == S_MOTOR) begin
            wr.channel = mot_ch;
            wr.last    = (r_sub == 2'd2) && (r_srv_pend == '0) && (mot_rest == '0);
            unique case (r_sub)
                2'd0: begin
                    wr.on_count  = (r_mag != '0 && !r_neg) ? PWM_FULL : 13'd0;
                    wr.off_count = (r_mag != '0 && !r_neg) ? 13'd0 : PWM_FULL;
                end
                2'd1: begin
                    wr.on_count  = (r_mag != '0 && r_neg) ? PWM_FULL : 13'd0;
                    wr.off_count = (r_mag != '0 && r_neg) ? 13'd0 : PWM_FULL;
                end
                default: begin
                    wr.on_count  = '0;
                    wr.off_count = (r_mag != '0) ? duty : PWM_FULL;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wdog_ticks <= WDOG_TICKS_RST;
            r_deadband   <= DEADBAND_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WDOG_TICKS) begin
                r_wdog_ticks <= i_cfg_data;
            end
            if (i_cfg_index == CFG_DEADBAND) begin
                r_deadband <= i_cfg_data[6:0];
            end
        end
    end

    // Sequencer: commands, tick planning, channel writes, watchdog
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mec_mode  <= 1'b0;
            r_wd        <= -9'sd1;
            r_srv_pend  <= '0;
            r_mot_pend  <= '0;
            r_srv_idx   <= '0;
            r_mot_idx   <= '0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_servo_cmd[i]  <= '0;
                r_servo_sent[i] <= '0;
            end
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_motor_cmd[i]  <= '0;
                r_motor_sent[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_mec_cmd[i]  <= '0;
                r_mec_sent[i] <= '0;
            end
        end else begin
            // load a new write, or drop a delivered one
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_head.kind)
                            K_MOTOR: begin
                                for (int i = 0; i < MOTOR_COUNT; i++) begin
                                    r_motor_cmd[i] <= 18'($signed(i_head.vals[i]));
                                end
                                r_mec_mode <= 1'b0;
                                r_wd       <= 9'($unsigned(r_wdog_ticks));
                            end
                            K_SERVO: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_servo_cmd[i] <= $signed(i_head.vals[i]);
                                end
                                r_mec_mode <= 1'b0;
                                r_wd       <= 9'($unsigned(r_wdog_ticks));
                            end
                            K_MECANUM: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_mec_cmd[i] <= $signed(i_head.vals[i]);
                                end
                                r_mec_mode <= 1'b1;
                                r_wd       <= 9'($unsigned(r_wdog_ticks));
                            end
                            default: begin
                                r_state <= S_PLAN;
                            end
                        endcase
                    end
                end
                S_PLAN: begin
                    for (int i = 0; i < 4; i++) begin
                        r_srv_pend[i]   <= (r_servo_cmd[i] != r_servo_sent[i]);
                        r_servo_sent[i] <= r_servo_cmd[i];
                    end
                    if (!r_mec_mode) begin
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            r_mot_pend[i]   <= (r_motor_cmd[i] != r_motor_sent[i]);
                            r_motor_sent[i] <= r_motor_cmd[i];
                        end
                    end else begin
                        r_mot_pend <= {MOTOR_COUNT{mec_diff}};
                        if (mec_diff) begin
                            for (int i = 0; i < 3; i++) begin
                                r_mec_sent[i] <= r_mec_cmd[i];
                            end
                            for (int i = 0; i < MOTOR_COUNT; i++) begin
                                r_motor_cmd[i] <= mix[i];
                            end
                        end
                    end
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_srv_pend != '0) begin
                        r_srv_idx <= srv_low;
                        r_p12     <= p12;
                        r_state   <= S_SERVO;
                    end else if (r_mot_pend != '0) begin
                        r_mot_idx <= mot_low;
                        r_mag     <= mag_sel;
                        r_neg     <= mv[17];
                        r_sub     <= '0;
                        r_state   <= S_MOTOR;
                    end else begin
                        r_state <= S_WDOG;
                    end
                end
                S_SERVO: begin
                    if (out_free) begin
                        r_out       <= wr;
                        r_srv_pend  <= srv_rest;
                        r_state     <= S_PICK;
                    end
                end
                S_MOTOR: begin
                    if (out_free) begin
                        r_out       <= wr;
                        if (r_sub == 2'd2) begin
                            r_mot_pend <= mot_rest;
                            r_state    <= S_PICK;
                        end else begin
                            r_sub <= r_sub + 2'd1;
                        end
                    end
                end
                S_WDOG: begin
                    // step the watchdog and zero all commands on expiry
                    if (!r_wd[8]) begin
                        r_wd <= r_wd - 9'sd1;
                        if (r_wd == 9'sd1) begin
                            for (int i = 0; i < 4; i++) begin
                                r_servo_cmd[i] <= '0;
                            end
                            for (int i = 0; i < MOTOR_COUNT; i++) begin
                                r_motor_cmd[i] <= '0;
                            end
                            for (int i = 0; i < 3; i++) begin
                                r_mec_cmd[i] <= '0;
                            end
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_wdog_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDOG && r_wd == 9'sd1) |=>
        (r_servo_cmd[0] == 16'sd0 && r_servo_cmd[3] == 16'sd0 && r_mec_cmd[0] == 16'sd0))
        else $error("watchdog expiry did not zero commands");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOTOR) |-> (r_mag <= MAG_MAX))
        else $error("motor magnitude out of range");

    a_pend_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PLAN) |=> ((r_srv_pend & ~$past(r_srv_pend)) == 4'b0))
        else $error("servo pending set outside planning");

    a_wdog_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDOG) |-> (r_srv_pend == '0 && r_mot_pend == '0))
        else $error("tick closed with writes pending");

endmodule
